// ===== hw/rtl/apa102_frame_generator_unit_defines.svh =====
// Assertion macros shared by the frame generator modules.
// Used by apa102fg_ctrl and apa102fg_dp; depends on nothing else.
`ifndef APA102_FRAME_GENERATOR_UNIT_DEFINES_SVH
`define APA102_FRAME_GENERATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked assertion, switched off while reset is asserted (active low)
`define APA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked assertion that also holds during reset
`define APA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APA_ASSERT(lbl, clk, rstn, prop, msg)
`define APA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/apa102fg_pkg.sv =====
// Shared types and constants for the APA102 frame generator.
// Used by the top level, apa102fg_ctrl and apa102fg_dp; depends on nothing.
`default_nettype none

package apa102fg_pkg;

    // default store size in LEDs
    localparam int MAX_PIXELS_DEFAULT = 256;

    // field widths
    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int COLOR_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int ORDER_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // bytes per LED in the store
    localparam int LANES = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ORDER = 2'd1;

    // register reset values
    localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = 9'd256;
    localparam logic [ORDER_W-1:0] COLOR_ORDER_RESET = 6'd36;

    // frame bytes
    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

    // start frame length and end frame rounding (one end byte per 16 LEDs)
    localparam int START_BYTES = 4;
    localparam int END_ROUND   = 15;
    localparam int END_SHIFT   = 4;

    // controller to datapath
    typedef struct packed {
        logic clear_en;   // clearing pass: write zero at the clear address
        logic accept;     // input beat taken this cycle
        logic load_ram;   // move RAM read data into the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last; // clear address is at the final row
        logic tick_reads; // beat on s_tdata is a tick that needs a store read
        logic out_valid;  // output register holds a beat
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/apa102_frame_generator_unit.sv =====
// APA102 frame generator, top level: controller, datapath and pixel store.
// Depends on apa102fg_pkg, apa102fg_ctrl, apa102fg_dp and apa102fg_ram.
//
// Use: the s_ channel carries commands. operation 0 writes a pixel (red, green,
// blue placed by the colour order register; indexes at or beyond the count are
// dropped), 1 arms a frame, 2 is a byte tick. Each tick while a frame is armed
// yields one beat on the m_ channel: four 0x00 bytes, then 0xFF and three colour
// bytes per LED, then ceil(count/16) bytes of 0xFF; tlast marks the final byte.
// Writes and starts yield no beat; ticks while idle are dropped.
// Timing: for ticks for start, LED header and end bytes the beat appears in the
// cycle after acceptance; for stored colour bytes the store lanes are read into
// their read registers, then the output register; s_tready is low meanwhile.
// Reset: aresetn sets registers to reset values and clears frame state, then a
// clearing pass zeroes every store row with s_tready low; configuration writes
// are still taken then. Config must be written only while the block is idle.
// Stall: a single output register holds the beat while m_tready is low; a new
// beat is taken once the register is empty or being emptied.
`default_nettype none

module apa102_frame_generator_unit #(
    parameter int MAX_PIXELS = apa102fg_pkg::MAX_PIXELS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // s_tdata: operation[1:0], pixel_index[9:2], red[17:10], green[25:18],
    // blue[33:26], zero fill [39:34]
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [apa102fg_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: out_byte[7:0]; m_tlast: last_byte
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [apa102fg_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                     m_tlast,
    input  wire logic                                cfg_wen,
    input  wire logic [apa102fg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [apa102fg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    apa102fg_pkg::ctrl_cmd_t  cmd;
    apa102fg_pkg::dp_status_t status;

    // sequencing
    apa102fg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and frame generation
    apa102fg_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/apa102fg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; depends on nothing.
`default_nettype none

module apa102fg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/apa102fg_ctrl.sv =====
// Controller for the frame generator: clearing pass, beat acceptance, store read wait.
// Depends on apa102fg_pkg and the assertion macro header.
`default_nettype none
`include "apa102_frame_generator_unit_defines.svh"

module apa102fg_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic                    m_tready,
    input  wire apa102fg_pkg::dp_status_t status,
    output apa102fg_pkg::ctrl_cmd_t      cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       ready;

    // take a beat only while idle and when the output register is free or being emptied
    assign ready    = (state_reg == ST_IDLE) && (!status.out_valid || m_tready);
    assign s_tready = ready;

    // drive commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.accept = s_tvalid && ready;
                if (cmd.accept && status.tick_reads) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.load_ram = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `APA_ASSERT(a_no_accept_in_clear, aclk, aresetn, (state_reg == ST_CLEAR) |-> !s_tready, "input taken during clearing pass")
    `APA_ASSERT(a_read_follows_tick, aclk, aresetn, (cmd.accept && status.tick_reads) |=> (state_reg == ST_READ), "store read not waited for")
    `APA_ASSERT(a_read_one_cycle, aclk, aresetn, (state_reg == ST_READ) |=> (state_reg == ST_IDLE), "read wait longer than one cycle")

endmodule

`default_nettype wire

// ===== hw/rtl/apa102fg_dp.sv =====
// Datapath for the frame generator: registers, pixel store lanes, frame cursors,
// output register. Depends on apa102fg_pkg, apa102fg_ram and the macro header.
`default_nettype none
`include "apa102_frame_generator_unit_defines.svh"

module apa102fg_dp #(
    parameter int MAX_PIXELS = apa102fg_pkg::MAX_PIXELS_DEFAULT
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic [apa102fg_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                                   m_tready,
    output logic                                        m_tvalid,
    output logic      [apa102fg_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                        m_tlast,
    input  wire logic                                   cfg_wen,
    input  wire logic [apa102fg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [apa102fg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire apa102fg_pkg::ctrl_cmd_t                cmd,
    output apa102fg_pkg::dp_status_t                    status
);

    localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW  = $clog2(MAX_PIXELS + 1);
    localparam int NW  = (CW > apa102fg_pkg::COUNT_W) ? CW : apa102fg_pkg::COUNT_W;
    localparam int ENDMAX = (MAX_PIXELS + apa102fg_pkg::END_ROUND) / 16;
    localparam int EW0 = $clog2(ENDMAX + 1);
    localparam int EW  = (EW0 > 3) ? EW0 : 3;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_PIXEL = 2'd1;
    localparam logic [1:0] PH_END   = 2'd2;

    // input fields
    logic [apa102fg_pkg::OP_W-1:0]    op;
    logic [apa102fg_pkg::IDX_W-1:0]   idx;
    logic [apa102fg_pkg::COLOR_W-1:0] red;
    logic [apa102fg_pkg::COLOR_W-1:0] green;
    logic [apa102fg_pkg::COLOR_W-1:0] blue;

    assign op    = s_tdata[1:0];
    assign idx   = s_tdata[9:2];
    assign red   = s_tdata[17:10];
    assign green = s_tdata[25:18];
    assign blue  = s_tdata[33:26];

    // registers and frame state
    logic [apa102fg_pkg::COUNT_W-1:0] pixel_count_reg;
    logic [apa102fg_pkg::ORDER_W-1:0] color_order_reg;
    logic                             active_reg, active_next;
    logic [1:0]                       phase_reg, phase_next;
    logic [NW-1:0]                    pcur_reg, pcur_next;
    logic [EW-1:0]                    bc_reg, bc_next;
    logic [AW-1:0]                    clr_cnt_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [apa102fg_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                             out_last_reg;
    logic [1:0]                       lane_reg;

    // effective count and end frame length
    logic [NW-1:0] count_ext;
    logic [NW-1:0] n;
    logic [NW:0]   endlen;

    assign count_ext = NW'(pixel_count_reg);
    assign n         = (count_ext > NW'(MAX_PIXELS)) ? NW'(MAX_PIXELS) : count_ext;
    assign endlen    = ((NW+1)'(n) + (NW+1)'(apa102fg_pkg::END_ROUND))
                       >> apa102fg_pkg::END_SHIFT;

    // pixel cursor past a shrunk count moves straight to the end frame
    logic          skip_to_end;
    logic [1:0]    eff_phase;
    logic [EW-1:0] eff_bc;
    logic [EW-1:0] bc_inc;
    logic          is_tick;

    assign skip_to_end = (phase_reg == PH_PIXEL) && (pcur_reg >= n);
    assign eff_phase   = skip_to_end ? PH_END : phase_reg;
    assign eff_bc      = skip_to_end ? '0 : bc_reg;
    assign bc_inc      = eff_bc + EW'(1);
    assign is_tick     = (op == apa102fg_pkg::OP_TICK) && active_reg;

    assign status.tick_reads = is_tick && (eff_phase == PH_PIXEL) && (eff_bc != '0);
    assign status.clear_last = (clr_cnt_reg == AW'(MAX_PIXELS - 1));
    assign status.out_valid  = out_valid_reg;

    // pixel write decode
    logic [1:0]      red_off, green_off, blue_off;
    logic            write_ok;
    logic [AW+7:0]   idx_wide;
    logic [AW-1:0]   idx_addr;

    assign red_off   = color_order_reg[1:0];
    assign green_off = color_order_reg[3:2];
    assign blue_off  = color_order_reg[5:4];
    assign write_ok  = cmd.accept && (op == apa102fg_pkg::OP_WRITE) && (NW'(idx) < n);
    assign idx_wide  = (AW+8)'(idx);
    assign idx_addr  = idx_wide[AW-1:0];

    // one RAM lane per byte position in a pixel
    logic [apa102fg_pkg::BYTE_W-1:0] lane_rdata [apa102fg_pkg::LANES];
    logic                            rd_en;

    assign rd_en = cmd.accept && status.tick_reads;

    for (genvar k = 0; k < apa102fg_pkg::LANES; k++) begin : g_lane
        logic                            hit_r, hit_g, hit_b;
        logic                            we;
        logic [apa102fg_pkg::BYTE_W-1:0] sel, wdata;
        logic [AW-1:0]                   waddr;

        assign hit_r = (red_off == 2'(k));
        assign hit_g = (green_off == 2'(k));
        assign hit_b = (blue_off == 2'(k));
        // later colour wins where offsets coincide
        assign sel   = hit_b ? blue : (hit_g ? green : red);
        assign we    = cmd.clear_en || (write_ok && (hit_r || hit_g || hit_b));
        assign wdata = cmd.clear_en ? apa102fg_pkg::BYTE_ZERO : sel;
        assign waddr = cmd.clear_en ? clr_cnt_reg : idx_addr;

        apa102fg_ram #(
            .WIDTH (apa102fg_pkg::BYTE_W),
            .DEPTH (MAX_PIXELS)
        ) u_ram (
            .aclk  (aclk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (rd_en),
            .raddr (pcur_reg[AW-1:0]),
            .rdata (lane_rdata[k])
        );
    end

    // frame sequencing on start and tick beats
    logic                            load_direct;
    logic [apa102fg_pkg::BYTE_W-1:0] direct_byte;
    logic                            direct_last;

    always_comb begin
        active_next = active_reg;
        phase_next  = phase_reg;
        pcur_next   = pcur_reg;
        bc_next     = bc_reg;
        direct_byte = apa102fg_pkg::BYTE_ONES;
        direct_last = 1'b0;
        load_direct = 1'b0;
        if (cmd.accept && (op == apa102fg_pkg::OP_START) && !active_reg) begin
            active_next = 1'b1;
            phase_next  = PH_START;
            pcur_next   = '0;
            bc_next     = '0;
        end else if (cmd.accept && is_tick) begin
            load_direct = !status.tick_reads;
            phase_next  = eff_phase;
            case (eff_phase)
                PH_START: begin
                    direct_byte = apa102fg_pkg::BYTE_ZERO;
                    bc_next     = bc_inc;
                    if (bc_inc == EW'(apa102fg_pkg::START_BYTES)) begin
                        bc_next   = '0;
                        pcur_next = '0;
                        if (n != '0) begin
                            phase_next = PH_PIXEL;
                        end else begin
                            direct_last = 1'b1;
                        end
                    end
                end
                PH_PIXEL: begin
                    bc_next = bc_inc;
                    if (bc_inc == EW'(apa102fg_pkg::START_BYTES)) begin
                        bc_next   = '0;
                        pcur_next = pcur_reg + NW'(1);
                        if ((pcur_reg + NW'(1)) >= n) begin
                            phase_next = PH_END;
                        end
                    end
                end
                default: begin
                    bc_next = bc_inc;
                    if ((NW+1)'(bc_inc) >= endlen) begin
                        direct_last = 1'b1;
                    end
                end
            endcase
            if (direct_last) begin
                active_next = 1'b0;
                phase_next  = PH_START;
                pcur_next   = '0;
                bc_next     = '0;
            end
        end
    end

    // output register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_direct || cmd.load_ram) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= apa102fg_pkg::PIXEL_COUNT_RESET;
            color_order_reg <= apa102fg_pkg::COLOR_ORDER_RESET;
            active_reg      <= 1'b0;
            phase_reg       <= PH_START;
            pcur_reg        <= '0;
            bc_reg          <= '0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wen && (cfg_index == apa102fg_pkg::REG_PIXEL_COUNT)) begin
                pixel_count_reg <= cfg_wdata[apa102fg_pkg::COUNT_W-1:0];
            end
            if (cfg_wen && (cfg_index == apa102fg_pkg::REG_COLOR_ORDER)) begin
                color_order_reg <= cfg_wdata[apa102fg_pkg::ORDER_W-1:0];
            end
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            pcur_reg      <= pcur_next;
            bc_reg        <= bc_next;
            out_valid_reg <= out_valid_next;
            if (cmd.clear_en) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // output payload and read lane capture
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            lane_reg <= eff_bc[1:0] - 2'd1;
        end
        if (load_direct) begin
            out_byte_reg <= direct_byte;
            out_last_reg <= direct_last;
        end else if (cmd.load_ram) begin
            case (lane_reg)
                2'd0:    out_byte_reg <= lane_rdata[0];
                2'd1:    out_byte_reg <= lane_rdata[1];
                2'd2:    out_byte_reg <= lane_rdata[2];
                default: out_byte_reg <= apa102fg_pkg::BYTE_ZERO;
            endcase
            out_last_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    `APA_ASSERT(a_ram_lands_in_free_slot, aclk, aresetn, cmd.load_ram |-> !out_valid_reg, "store byte would overwrite a waiting beat")
    `APA_ASSERT(a_idle_cursors_clear, aclk, aresetn, !active_reg |-> ((phase_reg == PH_START) && (pcur_reg == '0) && (bc_reg == '0)), "frame state left over while idle")
    `APA_ASSERT(a_last_ends_frame, aclk, aresetn, (load_direct && direct_last) |=> !active_reg, "frame still active after last byte")

endmodule

`default_nettype wire
